// ===== hw/rtl/vna_pkg.sv =====
// vna_pkg: shared field widths, request and status codes for the vertex normal accumulator
// no dependencies; imported by the accumulator, its checker and the testbench
`default_nettype none

package vna_pkg;

  // item field widths
  localparam int unsigned IdxW   = 10;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CntW   = 11;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 48;

  // request kinds
  localparam logic [ReqW-1:0] REQ_LOAD  = 2'd0;
  localparam logic [ReqW-1:0] REQ_TRI   = 2'd1;
  localparam logic [ReqW-1:0] REQ_QUERY = 2'd2;

  // result status
  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_IDX  = 2'd1;
  localparam logic [StatW-1:0] ST_ZERO = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/vertex_normal_accumulator.sv =====
// vertex_normal_accumulator: area-weighted smooth vertex normals over on-chip stores
// depends on vna_pkg
//
// One item is taken at a time and each gives one result item. A triangle makes
// three position reads, six products through the shared 32x32 multiplier, then
// a read and a saturating write of the sums for each corner. A query runs the
// one-bit-a-cycle scaling shift, the squares on the shared multiplier, the
// bit-serial square root and the bit-serial divider for each component; a query
// of a zero sum skips them. The result sits in an output register, so the next
// item is taken while it waits. Stores are not cleared after reset; reading a
// vertex that was never loaded gives undefined data.
`default_nettype none

module vertex_normal_accumulator #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned SUM_BITS     = 42
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write: vertex_count
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vna_pkg::CntW-1:0]      cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  wire logic [vna_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  wire logic [vna_pkg::ReqW-1:0]      s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [vna_pkg::OutDataW-1:0]       m_axis_tdata,
  // status
  output logic [vna_pkg::StatW-1:0]          m_axis_tuser
);
  import vna_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned SB  = SUM_BITS;
  localparam int unsigned FW  = 2 * CB + 3;
  localparam int unsigned EW  = ((SB > FW) ? SB : FW) + 1;
  localparam int unsigned NUMW = 46;

  localparam logic signed [EW-1:0] SUM_HI = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [EW-1:0] SUM_LO = ~SUM_HI;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRD   = 4'd1;
  localparam logic [3:0] S_TMUL  = 4'd2;
  localparam logic [3:0] S_TSRD  = 4'd3;
  localparam logic [3:0] S_TSWR  = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QLD   = 4'd6;
  localparam logic [3:0] S_QSH   = 4'd7;
  localparam logic [3:0] S_QSQ   = 4'd8;
  localparam logic [3:0] S_QSQRT = 4'd9;
  localparam logic [3:0] S_QDSET = 4'd10;
  localparam logic [3:0] S_QDIV  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;

  logic [CntW-1:0] vcount_q;

  // input fields
  logic [IdxW-1:0] in_vi, in_ca, in_cb, in_cc;
  logic [PosW-1:0] in_px, in_py, in_pz;
  assign in_vi = s_axis_tdata[9:0];
  assign in_px = s_axis_tdata[25:10];
  assign in_py = s_axis_tdata[41:26];
  assign in_pz = s_axis_tdata[57:42];
  assign in_ca = s_axis_tdata[67:58];
  assign in_cb = s_axis_tdata[77:68];
  assign in_cc = s_axis_tdata[87:78];

  function automatic logic in_range(input logic [IdxW-1:0] idx, input logic [CntW-1:0] vc);
    in_range = (32'(idx) < 32'(vc)) && (32'(idx) < MAX_VERTICES);
  endfunction

  // memories
  logic [3*CB-1:0] pos_mem [MAX_VERTICES];
  logic [SB-1:0]   sx_mem  [MAX_VERTICES];
  logic [SB-1:0]   sy_mem  [MAX_VERTICES];
  logic [SB-1:0]   sz_mem  [MAX_VERTICES];
  logic [3*CB-1:0] pos_rd_q;
  logic [SB-1:0]   sx_rd_q, sy_rd_q, sz_rd_q;

  logic            pos_we, sum_we;
  logic [AW-1:0]   pos_waddr, pos_raddr, sum_addr_w, sum_raddr;
  logic [3*CB-1:0] pos_wdata;
  logic [SB-1:0]   sx_wd, sy_wd, sz_wd;

  // working registers
  logic [AW-1:0]          crn_q [3];
  logic [3*CB-1:0]        p_q   [3];
  logic signed [FW-1:0]   f_q   [3];
  logic signed [63:0]     prod_q;
  logic [SB-1:0]          m_q   [3];
  logic [SB-1:0]          mx_q;
  logic [2:0]             neg_q;
  logic [63:0]            x_q, r_q, bit_q;
  logic [NUMW-1:0]        num_q;
  logic [31:0]            rem_q;
  logic [15:0]            quot_q;
  logic [NrmW-1:0]        nrm_q [3];
  logic [StatW-1:0]       st_q;

  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q;
  logic [StatW-1:0]       out_user_q;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // coordinate differences for the cross product
  logic signed [CB:0] u [3];
  logic signed [CB:0] v [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = (CB+1)'($signed(p_q[1][k*CB +: CB])) - (CB+1)'($signed(p_q[0][k*CB +: CB]));
      v[k] = (CB+1)'($signed(p_q[2][k*CB +: CB])) - (CB+1)'($signed(p_q[0][k*CB +: CB]));
    end
  end

  // shared multiplier operand select
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_TMUL) begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = 32'(u[1]); mul_b = 32'(v[2]); end
        3'd1: begin mul_a = 32'(u[2]); mul_b = 32'(v[1]); end
        3'd2: begin mul_a = 32'(u[2]); mul_b = 32'(v[0]); end
        3'd3: begin mul_a = 32'(u[0]); mul_b = 32'(v[2]); end
        3'd4: begin mul_a = 32'(u[0]); mul_b = 32'(v[1]); end
        3'd5: begin mul_a = 32'(u[1]); mul_b = 32'(v[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_QSQ && cnt_q[1:0] != 2'd3) begin
      mul_a = {1'b0, m_q[cnt_q[1:0]][30:0]};
      mul_b = {1'b0, m_q[cnt_q[1:0]][30:0]};
    end
  end

  // saturating sum update
  function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a, input logic signed [FW-1:0] b);
    logic signed [EW-1:0] s;
    s = EW'($signed(a)) + EW'(b);
    if (s > SUM_HI)      sat_add = SB'(SUM_HI);
    else if (s < SUM_LO) sat_add = SB'(SUM_LO);
    else                 sat_add = SB'(s);
  endfunction

  // sum magnitudes at query load
  logic [SB-1:0] mag [3];
  logic [SB-1:0] mx_c;
  always_comb begin
    mag[0] = sx_rd_q[SB-1] ? SB'(-sx_rd_q) : sx_rd_q;
    mag[1] = sy_rd_q[SB-1] ? SB'(-sy_rd_q) : sy_rd_q;
    mag[2] = sz_rd_q[SB-1] ? SB'(-sz_rd_q) : sz_rd_q;
    mx_c = mag[0];
    if (mag[1] > mx_c) mx_c = mag[1];
    if (mag[2] > mx_c) mx_c = mag[2];
  end

  // square root and divider steps
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [32:0] div_sh;
  logic        div_ge;
  logic [15:0] quot_c;
  assign sq_t   = r_q + bit_q;
  assign sq_ge  = (x_q >= sq_t);
  assign div_sh = {rem_q, num_q[NUMW-1]};
  assign div_ge = (div_sh >= {1'b0, r_q[31:0]});
  assign quot_c = {quot_q[14:0], div_ge};

  // memory port control
  always_comb begin
    pos_we     = accept && (s_axis_tuser == REQ_LOAD) && in_range(in_vi, vcount_q);
    pos_waddr  = AW'(in_vi);
    pos_wdata  = {CB'(32'(in_pz)), CB'(32'(in_py)), CB'(32'(in_px))};
    pos_raddr  = crn_q[cnt_q[1:0]];
    sum_raddr  = crn_q[cnt_q[1:0]];
    if (state_q == S_QRD) sum_raddr = crn_q[0];
    sum_we     = pos_we || (state_q == S_TSWR);
    sum_addr_w = pos_we ? AW'(in_vi) : crn_q[cnt_q[1:0]];
    if (pos_we) begin
      sx_wd = '0;
      sy_wd = '0;
      sz_wd = '0;
    end else begin
      sx_wd = sat_add(sx_rd_q, f_q[0]);
      sy_wd = sat_add(sy_rd_q, f_q[1]);
      sz_wd = sat_add(sz_rd_q, f_q[2]);
    end
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sx_mem[sum_addr_w] <= sx_wd;
      sy_mem[sum_addr_w] <= sy_wd;
      sz_mem[sum_addr_w] <= sz_wd;
    end
    sx_rd_q <= sx_mem[sum_raddr];
    sy_rd_q <= sy_mem[sum_raddr];
    sz_rd_q <= sz_mem[sum_raddr];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d  = '0;
        comp_d = '0;
        if (accept) begin
          state_d = S_FIN;
          if (s_axis_tuser == REQ_TRI && in_range(in_ca, vcount_q) &&
              in_range(in_cb, vcount_q) && in_range(in_cc, vcount_q)) begin
            state_d = S_TRD;
          end else if (s_axis_tuser == REQ_QUERY && in_range(in_vi, vcount_q)) begin
            state_d = S_QRD;
          end
        end
      end
      S_TRD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = S_TMUL;
          cnt_d   = '0;
        end
      end
      S_TMUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd6) begin
          state_d = S_TSRD;
          cnt_d   = '0;
        end
      end
      S_TSRD: state_d = S_TSWR;
      S_TSWR: begin
        cnt_d   = cnt_q + 6'd1;
        state_d = (cnt_q == 6'd2) ? S_FIN : S_TSRD;
      end
      S_QRD:  state_d = S_QLD;
      S_QLD:  state_d = (mx_c == '0) ? S_FIN : S_QSH;
      S_QSH: begin
        if (!(|mx_q[SB-1:31]) && (|mx_q[SB-1:30])) begin
          state_d = S_QSQ;
          cnt_d   = '0;
        end
      end
      S_QSQ: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = S_QSQRT;
          cnt_d   = '0;
        end
      end
      S_QSQRT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = S_QDSET;
          comp_d  = '0;
        end
      end
      S_QDSET: begin
        state_d = S_QDIV;
        cnt_d   = '0;
      end
      S_QDIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NUMW-1)) begin
          if (comp_q == 2'd2) begin
            state_d = S_FIN;
          end else begin
            state_d = S_QDSET;
            comp_d  = comp_q + 2'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      vcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      if (cfg_valid_i) vcount_q <= cfg_data_i;
      if (state_q == S_FIN && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        st_q     <= ST_IDX;
        nrm_q[0] <= '0;
        nrm_q[1] <= '0;
        nrm_q[2] <= '0;
        if (s_axis_tuser == REQ_TRI) begin
          crn_q[0] <= AW'(in_ca);
          crn_q[1] <= AW'(in_cb);
          crn_q[2] <= AW'(in_cc);
        end else begin
          crn_q[0] <= AW'(in_vi);
        end
        if ((s_axis_tuser == REQ_LOAD && in_range(in_vi, vcount_q)) ||
            (s_axis_tuser == REQ_TRI && in_range(in_ca, vcount_q) &&
             in_range(in_cb, vcount_q) && in_range(in_cc, vcount_q)) ||
            (s_axis_tuser == REQ_QUERY && in_range(in_vi, vcount_q))) begin
          st_q <= ST_OK;
        end
      end
      S_TRD: begin
        if (cnt_q != 6'd0) p_q[cnt_q[1:0] - 2'd1] <= pos_rd_q;
      end
      S_TMUL: begin
        if (cnt_q != 6'd0) begin
          if (!cnt_q[0]) f_q[cnt_q[2:1] - 2'd1] <= f_q[cnt_q[2:1] - 2'd1] - FW'(prod_q);
          else           f_q[cnt_q[2:1]]        <= FW'(prod_q);
        end
      end
      S_QLD: begin
        m_q[0] <= mag[0];
        m_q[1] <= mag[1];
        m_q[2] <= mag[2];
        mx_q   <= mx_c;
        neg_q  <= {sz_rd_q[SB-1], sy_rd_q[SB-1], sx_rd_q[SB-1]};
        if (mx_c == '0) st_q <= ST_ZERO;
      end
      S_QSH: begin
        if (|mx_q[SB-1:31]) begin
          mx_q <= mx_q >> 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end else if (!(|mx_q[SB-1:30])) begin
          mx_q <= mx_q << 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end
      end
      S_QSQ: begin
        if (cnt_q == 6'd1)      x_q <= prod_q;
        else if (cnt_q != 6'd0) x_q <= x_q + prod_q;
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
      end
      S_QSQRT: begin
        if (sq_ge) begin
          x_q <= x_q - sq_t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_QDSET: begin
        num_q  <= (NUMW'(m_q[comp_q][30:0]) << 14) + NUMW'(r_q[31:1]);
        rem_q  <= '0;
        quot_q <= '0;
      end
      S_QDIV: begin
        rem_q  <= div_ge ? 32'(div_sh - {1'b0, r_q[31:0]}) : div_sh[31:0];
        num_q  <= num_q << 1;
        quot_q <= quot_c;
        if (cnt_q == 6'(NUMW-1)) nrm_q[comp_q] <= neg_q[comp_q] ? -quot_c : quot_c;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {nrm_q[2], nrm_q[1], nrm_q[0]};
          out_user_q <= st_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vna_checker.sv =====
// vna_checker: port-level assertions for the vertex normal accumulator
// depends on vna_pkg; bound to vertex_normal_accumulator below
`default_nettype none

module vna_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [vna_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic [vna_pkg::StatW-1:0]     m_axis_tuser
);
  import vna_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

  // failed items carry zero normals
  a_zero_nrm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("nonzero normal on failed item");

  // unit normal components stay within one
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[15:0]) <= 16'sd16384 && $signed(m_axis_tdata[15:0]) >= -16'sd16384 &&
      $signed(m_axis_tdata[31:16]) <= 16'sd16384 && $signed(m_axis_tdata[31:16]) >= -16'sd16384 &&
      $signed(m_axis_tdata[47:32]) <= 16'sd16384 && $signed(m_axis_tdata[47:32]) >= -16'sd16384)
    else $error("normal component out of range");

  // no status code beyond zero-length
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_IDX || m_axis_tuser == ST_ZERO)
    else $error("bad status code");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

`default_nettype wire

// ===== test/tb_vertex_normal_accumulator.sv =====
// tb_vertex_normal_accumulator: self-checking testbench for the vertex normal accumulator
// depends on vna_pkg and vertex_normal_accumulator; predicts each result and compares per field
`default_nettype none

module tb_vertex_normal_accumulator;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int unsigned NumVert = 1024;
  localparam longint SumHi = (64'sd1 <<< 41) - 1;
  localparam longint SumLo = -(64'sd1 <<< 41);
  localparam longint CycleLimit = 2000000;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [NrmW-1:0]  nx;
    logic [NrmW-1:0]  ny;
    logic [NrmW-1:0]  nz;
  } normal_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CntW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [ReqW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0] m_axis_tuser;

  vertex_normal_accumulator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned vert_limit;
  longint pos_mem [NumVert][3];
  longint sum_mem [NumVert][3];
  bit loaded [NumVert];
  normal_result_t expected_normals[$];
  int err_count = 0;
  bit sink_stall_en = 1'b1;
  longint cycle_count = 0;

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SumHi) return SumHi;
    if (r < SumLo) return SumLo;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected result of one item, updates the predictor state
  function automatic normal_result_t predict_normal(logic [ReqW-1:0] req, int unsigned vi,
                                                    longint px, longint py, longint pz,
                                                    int unsigned ca, int unsigned cb,
                                                    int unsigned cc);
    normal_result_t r;
    longint u[3], v[3], f[3];
    longint unsigned m[3], mx, len, q;
    int unsigned c[3];
    r = '0;
    c[0] = ca; c[1] = cb; c[2] = cc;
    case (req)
      REQ_LOAD: begin
        if (vi < vert_limit) begin
          pos_mem[vi][0] = px; pos_mem[vi][1] = py; pos_mem[vi][2] = pz;
          for (int k = 0; k < 3; k++) sum_mem[vi][k] = 0;
          loaded[vi] = 1'b1;
        end else r.status = ST_IDX;
      end
      REQ_TRI: begin
        if (ca >= vert_limit || cb >= vert_limit || cc >= vert_limit) begin
          r.status = ST_IDX;
        end else begin
          for (int k = 0; k < 3; k++) begin
            u[k] = pos_mem[cb][k] - pos_mem[ca][k];
            v[k] = pos_mem[cc][k] - pos_mem[ca][k];
          end
          f[0] = u[1] * v[2] - u[2] * v[1];
          f[1] = u[2] * v[0] - u[0] * v[2];
          f[2] = u[0] * v[1] - u[1] * v[0];
          for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++) sum_mem[c[j]][k] = sat_sum(sum_mem[c[j]][k], f[k]);
        end
      end
      REQ_QUERY: begin
        if (vi >= vert_limit) begin
          r.status = ST_IDX;
        end else begin
          for (int k = 0; k < 3; k++)
            m[k] = sum_mem[vi][k] < 0 ? -sum_mem[vi][k] : sum_mem[vi][k];
          mx = m[0];
          if (m[1] > mx) mx = m[1];
          if (m[2] > mx) mx = m[2];
          if (mx == 0) begin
            r.status = ST_ZERO;
          end else begin
            while (mx >= (64'd1 << 31)) begin
              mx >>= 1;
              for (int k = 0; k < 3; k++) m[k] >>= 1;
            end
            while (mx < (64'd1 << 30)) begin
              mx <<= 1;
              for (int k = 0; k < 3; k++) m[k] <<= 1;
            end
            len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int k = 0; k < 3; k++) begin
              q = (m[k] * 16384 + (len >> 1)) / len;
              f[k] = sum_mem[vi][k] < 0 ? -longint'(q) : longint'(q);
            end
            r.nx = f[0][NrmW-1:0];
            r.ny = f[1][NrmW-1:0];
            r.nz = f[2][NrmW-1:0];
          end
        end
      end
      default: r.status = ST_IDX;
    endcase
    return r;
  endfunction

  // send one item, predict its result on acceptance
  task automatic send_item(logic [ReqW-1:0] req, int unsigned vi, logic [PosW-1:0] px,
                           logic [PosW-1:0] py, logic [PosW-1:0] pz, int unsigned ca,
                           int unsigned cb, int unsigned cc);
    int unsigned gap;
    gap = rand_gap();
    // the block is busy right after it takes an item, so waiting before driving costs nothing
    repeat (gap + 1) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {cc[IdxW-1:0], cb[IdxW-1:0], ca[IdxW-1:0], pz, py, px, vi[IdxW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_normals.push_back(predict_normal(req, vi, longint'(signed'(px)),
                                              longint'(signed'(py)), longint'(signed'(pz)),
                                              ca, cb, cc));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic load_vertex(int unsigned vi, logic [PosW-1:0] px, logic [PosW-1:0] py,
                             logic [PosW-1:0] pz);
    send_item(REQ_LOAD, vi, px, py, pz, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  task automatic add_triangle(int unsigned ca, int unsigned cb, int unsigned cc);
    send_item(REQ_TRI, $urandom_range(0, 1023), PosW'($urandom), PosW'($urandom),
              PosW'($urandom), ca, cb, cc);
  endtask

  task automatic query_vertex(int unsigned vi);
    send_item(REQ_QUERY, vi, PosW'($urandom), PosW'($urandom), PosW'($urandom),
              $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // wait for all results, then the query latency, then write vertex_count
  task automatic set_vertex_count(int unsigned cnt);
    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt[CntW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    vert_limit = cnt > NumVert ? NumVert : cnt;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker with random backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= sink_stall_en ? (rand_gap() == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    normal_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_normals.size() == 0) begin
        $error("result with nothing expected: status %0d", m_axis_tuser);
        err_count++;
      end else begin
        exp_r = expected_normals.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, m_axis_tuser); err_count++;
        end
        if (m_axis_tdata[15:0] !== exp_r.nx) begin
          $error("normal_x exp %0h got %0h", exp_r.nx, m_axis_tdata[15:0]); err_count++;
        end
        if (m_axis_tdata[31:16] !== exp_r.ny) begin
          $error("normal_y exp %0h got %0h", exp_r.ny, m_axis_tdata[31:16]); err_count++;
        end
        if (m_axis_tdata[47:32] !== exp_r.nz) begin
          $error("normal_z exp %0h got %0h", exp_r.nz, m_axis_tdata[47:32]); err_count++;
        end
      end
    end
  end

  // directed: extremes, every request kind, special cases
  task automatic test_directed();
    set_vertex_count(0);
    load_vertex(0, 16'h1234, 16'h0, 16'h0);
    query_vertex(0);
    add_triangle(0, 0, 0);
    set_vertex_count(1024);
    load_vertex(0, 16'h8000, 16'h8000, 16'h8000);
    load_vertex(1, 16'h7fff, 16'h8000, 16'h8000);
    load_vertex(2, 16'h8000, 16'h7fff, 16'h8000);
    load_vertex(1023, 16'h7fff, 16'h7fff, 16'h7fff);
    query_vertex(0);
    for (int i = 0; i < 8; i++) add_triangle(0, 1, 2);
    add_triangle(2, 1, 0);
    add_triangle(0, 0, 1023);
    add_triangle(1023, 1023, 1023);
    query_vertex(0);
    query_vertex(1);
    query_vertex(1023);
    send_item(ReqUnused, 0, 16'hffff, 16'hffff, 16'hffff, 1023, 1023, 1023);
    set_vertex_count(2047);
    query_vertex(1023);
    set_vertex_count(3);
    load_vertex(3, 16'h0100, 16'h0, 16'h0);
    add_triangle(0, 1, 3);
    query_vertex(1023);
    query_vertex(2);
  endtask

  // random meshes: load a small set, add triangles, query, with some noise
  task automatic test_random_mesh();
    int unsigned nv, sent, pick;
    int unsigned idx[3];
    sent = 0;
    while (sent < 1200) begin
      nv = $urandom_range(0, 7) == 0 ? $urandom_range(3, 1024) : $urandom_range(3, 40);
      set_vertex_count($urandom_range(0, 5) == 0 ? $urandom_range(nv, 2047) : nv);
      sink_stall_en = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 8 && sent < 1200; i++) begin
        pick = $urandom_range(0, nv - 1);
        load_vertex(pick, PosW'($urandom), PosW'($urandom), PosW'($urandom));
        sent++;
      end
      for (int i = 0; i < 40 && sent < 1200; i++) begin
        pick = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
          do idx[k] = $urandom_range(0, nv - 1); while (!loaded[idx[k]]);
        end
        if (pick < 4) add_triangle(idx[0], idx[1], idx[2]);
        else if (pick < 7) query_vertex(idx[0]);
        else if (pick == 7) load_vertex(idx[0], PosW'($urandom), PosW'($urandom),
                                        PosW'($urandom));
        else if (pick == 8) begin
          // out of range index, nothing changes; a loaded vertex when all are in range
          if (vert_limit < NumVert) pick = $urandom_range(vert_limit, NumVert - 1);
          else pick = idx[1];
          if ($urandom_range(0, 1) == 0) query_vertex(pick);
          else add_triangle(idx[0], pick, idx[2]);
        end else send_item(ReqUnused, $urandom_range(0, 1023), PosW'($urandom),
                           PosW'($urandom), PosW'($urandom),
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
        sent++;
      end
    end
    sink_stall_en = 1'b1;
  endtask

  initial begin
    vert_limit = 0;
    for (int i = 0; i < NumVert; i++) loaded[i] = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_mesh();
    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (err_count == 0 && expected_normals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
